// ----- src/e2c_pkg.sv -----
// ----------------------------------------------------------------------------
// e2c_pkg: shared types and constants for the epoch to calendar date block
// Holds the sequencer state type, the calendar constants and the month table.
// ----------------------------------------------------------------------------
package e2c_pkg;

  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned DAYS_PER_QUAD = 1461;
  localparam int unsigned DAYS_PER_WEEK = 7;
  localparam int unsigned EPOCH_WEEKDAY = 4;
  localparam int unsigned BASE_YEAR     = 1970;

  // Day count boundaries inside one four-year group; the third year is the leap year.
  localparam logic [10:0] QUAD_Y1 = 11'd365;
  localparam logic [10:0] QUAD_Y2 = 11'd730;
  localparam logic [10:0] QUAD_Y3 = 11'd1096;
  localparam logic [1:0]  LEAP_OFFSET = 2'd2;

  localparam logic [3:0]  LAST_MONTH = 4'd11;
  localparam logic [3:0]  FEBRUARY   = 4'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DAY,
    ST_SPLIT,
    ST_MIN,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } e2c_state_t;

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    unique case (mon)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
      FEBRUARY:                                  len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- src/epoch_to_calendar_date.sv -----
// ----------------------------------------------------------------------------
// epoch_to_calendar_date: seconds since 1970 to calendar date and time
// Serial conversion of a 32-bit epoch count into time of day, weekday and date.
// ----------------------------------------------------------------------------
// Usage:
// A request on the in_ channel carries a 32-bit count of seconds since
// 1970-01-01 00:00:00. It is taken when in_valid is high and in_stall is low;
// in_stall is high while a conversion is in progress.
// The result leaves on the out_ channel from an output register and is held
// until a cycle with out_valid high and out_stall low.
// Conversion from the accepting edge to out_valid runs as bit-serial
// divisions by 86400 (32 steps), by 60 (17 steps) and by 60 again (11 steps),
// then a year pick and a month search of 1 to 12 steps. The day
// split into four-year groups and the weekday run beside the first division
// by 60. The next request is taken once the result is in the output register,
// so a stalled receiver holds up only the end of the following conversion.
// Leap years are all years divisible by four, so dates from March 2100 on
// are one day late. Reset clears the sequencer and drops out_valid.
// ----------------------------------------------------------------------------
module epoch_to_calendar_date
  import e2c_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_seconds_since_1970,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_second,
  output logic [5:0]  out_minute,
  output logic [4:0]  out_hour,
  output logic [2:0]  out_weekday,
  output logic [4:0]  out_day_of_month,
  output logic [3:0]  out_month,
  output logic [11:0] out_full_year
);

  e2c_state_t state_r, state_nxt;

  logic        day_start, sec_start, min_start;
  logic        year_load, month_step, out_load;
  logic        day_busy, sec_busy, min_busy, quad_busy, wk_busy;
  logic [31:0] day_quo;
  logic [16:0] day_rem;
  logic [16:0] sec_quo;
  logic [5:0]  sec_rem;
  logic [10:0] min_quo;
  logic [5:0]  min_rem;
  logic [15:0] quad_quo;
  logic [10:0] quad_rem;
  logic [15:0] wk_quo;
  logic [2:0]  wk_rem;
  logic [15:0] wk_din;

  logic [1:0]  yoff;
  logic [10:0] yday;
  logic [8:0]  diy_r, diy_nxt;
  logic [3:0]  mon_r, mon_nxt;
  logic [11:0] year_r, year_nxt;
  logic        leap_r, leap_nxt;
  logic [4:0]  mlen;
  logic        month_end;

  logic        out_valid_r, out_valid_nxt;
  logic [5:0]  second_r, minute_r;
  logic [4:0]  hour_r, dom_r;
  logic [2:0]  weekday_r;
  logic [3:0]  month_r;
  logic [11:0] full_year_r;

  // Whole days and second of day.
  e2c_sdiv #(.DW(32), .RW(17), .DIVISOR(SECS_PER_DAY)) u_day (
    .clk(clk), .rst_n(rst_n), .start(day_start), .din(in_seconds_since_1970),
    .busy(day_busy), .quo(day_quo), .rem(day_rem)
  );

  // Minute of day and second.
  e2c_sdiv #(.DW(17), .RW(6), .DIVISOR(SECS_PER_MIN)) u_sec (
    .clk(clk), .rst_n(rst_n), .start(sec_start), .din(day_rem),
    .busy(sec_busy), .quo(sec_quo), .rem(sec_rem)
  );

  // Hour and minute.
  e2c_sdiv #(.DW(11), .RW(6), .DIVISOR(SECS_PER_MIN)) u_min (
    .clk(clk), .rst_n(rst_n), .start(min_start), .din(sec_quo[10:0]),
    .busy(min_busy), .quo(min_quo), .rem(min_rem)
  );

  // Four-year groups and the day within a group.
  e2c_sdiv #(.DW(16), .RW(11), .DIVISOR(DAYS_PER_QUAD)) u_quad (
    .clk(clk), .rst_n(rst_n), .start(sec_start), .din(day_quo[15:0]),
    .busy(quad_busy), .quo(quad_quo), .rem(quad_rem)
  );

  // The epoch day was a Thursday.
  assign wk_din = day_quo[15:0] + 16'(EPOCH_WEEKDAY);

  e2c_sdiv #(.DW(16), .RW(3), .DIVISOR(DAYS_PER_WEEK)) u_wk (
    .clk(clk), .rst_n(rst_n), .start(sec_start), .din(wk_din),
    .busy(wk_busy), .quo(wk_quo), .rem(wk_rem)
  );

  // Year within the four-year group.
  always_comb begin
    priority if (quad_rem < QUAD_Y1) begin
      yoff = 2'd0;
      yday = quad_rem;
    end else if (quad_rem < QUAD_Y2) begin
      yoff = 2'd1;
      yday = quad_rem - QUAD_Y1;
    end else if (quad_rem < QUAD_Y3) begin
      yoff = 2'd2;
      yday = quad_rem - QUAD_Y2;
    end else begin
      yoff = 2'd3;
      yday = quad_rem - QUAD_Y3;
    end
  end

  assign mlen      = month_len(mon_r, leap_r);
  assign month_end = (mon_r == LAST_MONTH) || (diy_r < {4'b0, mlen});

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_DAY;
      ST_DAY:   if (!day_busy) state_nxt = ST_SPLIT;
      ST_SPLIT: if (!sec_busy && !quad_busy && !wk_busy) state_nxt = ST_MIN;
      ST_MIN:   if (!min_busy) state_nxt = ST_YEAR;
      ST_YEAR:  state_nxt = ST_MONTH;
      ST_MONTH: if (month_end) state_nxt = ST_DONE;
      ST_DONE:  if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall   = 1'b1;
    day_start  = 1'b0;
    sec_start  = 1'b0;
    min_start  = 1'b0;
    year_load  = 1'b0;
    month_step = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        day_start = in_valid;
      end
      ST_DAY:   sec_start  = !day_busy;
      ST_SPLIT: min_start  = !sec_busy && !quad_busy && !wk_busy;
      ST_MIN:   year_load  = 1'b0;
      ST_YEAR:  year_load  = 1'b1;
      ST_MONTH: month_step = !month_end;
      ST_DONE:  out_load   = !out_valid_r || !out_stall;
      default:  in_stall   = 1'b1;
    endcase
  end

  always_comb begin
    diy_nxt  = diy_r;
    mon_nxt  = mon_r;
    year_nxt = year_r;
    leap_nxt = leap_r;
    if (year_load) begin
      diy_nxt  = yday[8:0];
      mon_nxt  = '0;
      // Four times the group count plus the offset is just the two fields side by side.
      year_nxt = 12'(BASE_YEAR) + 12'({quad_quo[5:0], yoff});
      leap_nxt = (yoff == LEAP_OFFSET);
    end else if (month_step) begin
      diy_nxt = diy_r - {4'b0, mlen};
      mon_nxt = mon_r + 1'b1;
    end
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    diy_r  <= diy_nxt;
    mon_r  <= mon_nxt;
    year_r <= year_nxt;
    leap_r <= leap_nxt;
    if (out_load) begin
      second_r    <= sec_rem;
      minute_r    <= min_rem;
      hour_r      <= min_quo[4:0];
      weekday_r   <= wk_rem;
      dom_r       <= diy_r[4:0] + 5'd1;
      month_r     <= mon_r + 4'd1;
      full_year_r <= year_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_second       = second_r;
  assign out_minute       = minute_r;
  assign out_hour         = hour_r;
  assign out_weekday      = weekday_r;
  assign out_day_of_month = dom_r;
  assign out_month        = month_r;
  assign out_full_year    = full_year_r;

endmodule

// ----- src/e2c_sdiv.sv -----
// ----------------------------------------------------------------------------
// e2c_sdiv: bit-serial divider by a constant
// Shifts the dividend in one bit per cycle, MSB first, and does one restoring
// compare and subtract per step.
// ----------------------------------------------------------------------------
module e2c_sdiv
  import e2c_pkg::*;
#(
  parameter int unsigned DW      = 32,
  parameter int unsigned RW      = 17,
  parameter int unsigned DIVISOR = SECS_PER_DAY
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] din,
  output logic          busy,
  output logic [DW-1:0] quo,
  output logic [RW-1:0] rem
);

  localparam int unsigned CW = $clog2(DW + 1);
  localparam logic [RW:0] DIV_K = (RW + 1)'(DIVISOR);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [RW:0]   trial;
  logic [RW:0]   diff;
  logic          ge;

  assign busy  = (cnt_r != '0);
  assign trial = {rem_r, quo_r[DW-1]};
  assign ge    = (trial >= DIV_K);
  assign diff  = trial - DIV_K;

  always_comb begin
    cnt_nxt = cnt_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    if (start) begin
      cnt_nxt = CW'(DW);
      quo_nxt = din;
      rem_nxt = '0;
    end else if (busy) begin
      cnt_nxt = cnt_r - 1'b1;
      quo_nxt = {quo_r[DW-2:0], ge};
      rem_nxt = ge ? diff[RW-1:0] : trial[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign quo = quo_r;
  assign rem = rem_r;

endmodule

// ----- tb/epoch_to_calendar_date_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// epoch_to_calendar_date_test: self-checking bench for the epoch converter
// Sends 32-bit second counts and checks every returned date and time against
// a behavioral calendar computed in the bench. Directed values cover the ends
// of the range, leap days and the year 2100. A random part follows, weighted
// toward year and month boundaries, leap days and the ends of the range.
// Sender gaps and receiver stalls are varied phase by phase.
// ----------------------------------------------------------------------------
module epoch_to_calendar_date_test;

  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [2:0]  weekday;
    logic [4:0]  day_of_month;
    logic [3:0]  month;
    logic [11:0] full_year;
  } cal_date_t;

  localparam int unsigned STUCK_LIMIT   = 4000;
  localparam int unsigned DRAIN_CYCLES  = 100;
  localparam int unsigned ITEMS_PER_RUN = 450;
  localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_seconds_since_1970 = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  out_second;
  logic [5:0]  out_minute;
  logic [4:0]  out_hour;
  logic [2:0]  out_weekday;
  logic [4:0]  out_day_of_month;
  logic [3:0]  out_month;
  logic [11:0] out_full_year;

  logic [31:0]  pending_stamps [$];
  cal_date_t    expected_dates [$];
  cal_date_t    want;
  bit           req_taken = 1'b0;
  int unsigned  gap_pct = 0;
  int unsigned  stall_pct = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  stuck_cycles = 0;

  epoch_to_calendar_date u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_seconds_since_1970 (in_seconds_since_1970),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_second            (out_second),
    .out_minute            (out_minute),
    .out_hour              (out_hour),
    .out_weekday           (out_weekday),
    .out_day_of_month      (out_day_of_month),
    .out_month             (out_month),
    .out_full_year         (out_full_year)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Month index runs from 0; every year divisible by four has a leap day.
  function automatic int unsigned days_in_month(input int unsigned mon0,
                                                input int unsigned year);
    if (mon0 == 1 && (year % 4) == 0) begin
      return 29;
    end
    return MONTH_DAYS[mon0];
  endfunction

  function automatic cal_date_t to_calendar(input logic [31:0] stamp);
    int unsigned rest;
    int unsigned days;
    int unsigned year;
    int unsigned mon0;
    cal_date_t   r;
    rest = stamp;
    r.second = 6'(rest % 60);
    rest = rest / 60;
    r.minute = 6'(rest % 60);
    rest = rest / 60;
    r.hour = 5'(rest % 24);
    days = rest / 24;
    // The epoch day was a Thursday.
    r.weekday = 3'((days + 4) % 7);
    year = 1970;
    while (days >= (((year % 4) == 0) ? 366 : 365)) begin
      days -= ((year % 4) == 0) ? 366 : 365;
      year++;
    end
    mon0 = 0;
    while (mon0 < 11 && days >= days_in_month(mon0, year)) begin
      days -= days_in_month(mon0, year);
      mon0++;
    end
    r.day_of_month = 5'(days + 1);
    r.month = 4'(mon0 + 1);
    r.full_year = 12'(year);
    return r;
  endfunction

  // Seconds since the epoch for a date and a second of the day.
  function automatic longint date_secs(input int unsigned year, input int unsigned month,
                                       input int unsigned day, input int unsigned sod);
    longint days;
    days = longint'(365) * (year - 1970) + (year - 1969) / 4;
    for (int unsigned m = 0; m + 1 < month; m++) begin
      days += days_in_month(m, year);
    end
    days += day - 1;
    return days * 86400 + sod;
  endfunction

  function automatic logic [31:0] random_stamp();
    int unsigned kind;
    int unsigned year;
    longint      t;
    kind = $urandom_range(9);
    t = -1;
    case (kind)
      4, 5: begin
        t = date_secs($urandom_range(1970, 2106), 1, 1, 0)
            + longint'($urandom_range(0, 7200)) - 3600;
      end
      6, 7: begin
        year = $urandom_range(1970, 2106);
        t = date_secs(year, $urandom_range(1, 12), 1, 0)
            + longint'($urandom_range(0, 7200)) - 3600;
      end
      8: begin
        year = 1972 + 4 * $urandom_range(0, 33);
        t = date_secs(year, 2, $urandom_range(28, 29), $urandom_range(0, 86399));
      end
      9: begin
        if ($urandom_range(1) == 0) begin
          t = $urandom_range(0, 200000);
        end else begin
          t = longint'(32'hFFFF_FFFF) - $urandom_range(0, 200000);
        end
      end
      default: begin
        t = -1;
      end
    endcase
    if (t < 0 || t > longint'(32'hFFFF_FFFF)) begin
      return $urandom;
    end
    return 32'(t);
  endfunction

  task automatic check_field(input string name, input logic [11:0] exp_val,
                             input logic [11:0] act_val);
    if (exp_val !== act_val) begin
      mismatch_count++;
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
    end
  endtask

  // Driver: a new request goes up only once the previous one was taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (pending_stamps.size() > 0 && $urandom_range(99) >= gap_pct) begin
        in_valid <= 1'b1;
        in_seconds_since_1970 <= pending_stamps.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Monitor, predictor hookup and watchdog.
  always @(posedge clk) begin
    if (!rst_n) begin
      req_taken = 1'b0;
    end else begin
      req_taken = in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (expected_dates.size() == 0) begin
          mismatch_count++;
          $error("result returned with no request outstanding");
        end else begin
          want = expected_dates.pop_front();
          check_field("second", 12'(want.second), 12'(out_second));
          check_field("minute", 12'(want.minute), 12'(out_minute));
          check_field("hour", 12'(want.hour), 12'(out_hour));
          check_field("weekday", 12'(want.weekday), 12'(out_weekday));
          check_field("day_of_month", 12'(want.day_of_month), 12'(out_day_of_month));
          check_field("month", 12'(want.month), 12'(out_month));
          check_field("full_year", want.full_year, out_full_year);
        end
      end
      if (req_taken) begin
        expected_dates.push_back(to_calendar(in_seconds_since_1970));
      end
      if (req_taken || (out_valid && !out_stall)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic drain();
    wait (pending_stamps.size() == 0 && !in_valid);
    wait (expected_dates.size() == 0);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Range ends, unit rollovers, leap days and the year 2100 leap day.
    pending_stamps.push_back(32'd0);
    pending_stamps.push_back(32'hFFFF_FFFF);
    pending_stamps.push_back(32'd59);
    pending_stamps.push_back(32'd60);
    pending_stamps.push_back(32'd3599);
    pending_stamps.push_back(32'd86399);
    pending_stamps.push_back(32'd86400);
    pending_stamps.push_back(32'(date_secs(1970, 12, 31, 86399)));
    pending_stamps.push_back(32'(date_secs(1971, 1, 1, 0)));
    pending_stamps.push_back(32'(date_secs(1972, 2, 28, 43200)));
    pending_stamps.push_back(32'(date_secs(1972, 2, 29, 0)));
    pending_stamps.push_back(32'(date_secs(1972, 2, 29, 86399)));
    pending_stamps.push_back(32'(date_secs(1972, 3, 1, 0)));
    pending_stamps.push_back(32'(date_secs(1972, 12, 31, 86399)));
    pending_stamps.push_back(32'(date_secs(1973, 2, 28, 86399)));
    pending_stamps.push_back(32'(date_secs(1973, 3, 1, 0)));
    pending_stamps.push_back(32'(date_secs(2000, 6, 15, 45296)));
    pending_stamps.push_back(32'(date_secs(2099, 12, 31, 86399)));
    pending_stamps.push_back(32'(date_secs(2100, 2, 29, 3723)));
    pending_stamps.push_back(32'(date_secs(2100, 3, 1, 0)));
    pending_stamps.push_back(32'h7FFF_FFFF);
    pending_stamps.push_back(32'h8000_0000);
    pending_stamps.push_back(32'hAAAA_AAAA);
    pending_stamps.push_back(32'h5555_5555);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 82; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 82; end
        default: begin gap_pct = 36; stall_pct = 36; end
      endcase
      for (int unsigned i = 0; i < ITEMS_PER_RUN; i++) begin
        pending_stamps.push_back(random_stamp());
      end
      drain();
    end

    stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_dates.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
